### sv/hds_pkg.sv
// package for the hyperbolic diophantine solver: widths, limits, state codes
// and the divider result bundle; no dependencies
package hds_pkg;

    localparam int COEF_WIDTH  = 16;
    localparam int MAX_LISTED  = 63;
    localparam int LIST_WIDTH  = $clog2(MAX_LISTED + 1);
    localparam int XY_WIDTH    = 34;
    localparam int PROD_WIDTH  = 2 * COEF_WIDTH + 1;
    localparam int DIVD_WIDTH  = PROD_WIDTH;
    localparam int DIVS_WIDTH  = COEF_WIDTH;
    localparam int CNT_WIDTH   = 16;
    localparam int DIV_STEPS   = DIVD_WIDTH;
    localparam int STEP_WIDTH  = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        STATUS_FINITE   = 2'd0,
        STATUS_INFINITE = 2'd1,
        STATUS_A_ZERO   = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AD,
        ST_MUL_BC,
        ST_CHECK,
        ST_ZERO_C,
        ST_ZERO_C_WAIT,
        ST_ZERO_B,
        ST_ZERO_B_WAIT,
        ST_LOOP,
        ST_DIV_I_WAIT,
        ST_CAND,
        ST_DIV_X_WAIT,
        ST_DIV_Y_WAIT,
        ST_FOUND,
        ST_NEXT_CAND,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic                  done;
        logic [DIVD_WIDTH-1:0] quot;
        logic [DIVS_WIDTH-1:0] rem;
    } div_res_t;

endpackage

### sv/hds_div.sv
// bit-serial restoring divider, unsigned, one quotient bit per cycle
// depends on hds_pkg
module hds_div import hds_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVD_WIDTH-1:0] dividend,
    input  logic [DIVS_WIDTH-1:0] divisor,
    output div_res_t              res
);

    logic [DIVS_WIDTH-1:0] rem_reg;
    logic [DIVD_WIDTH-1:0] quo_reg;
    logic [DIVS_WIDTH-1:0] dvs_reg;
    logic [STEP_WIDTH-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVS_WIDTH:0]   shifted;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DIVD_WIDTH-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_WIDTH'(DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_reg <= fits ? DIVS_WIDTH'(shifted - {1'b0, dvs_reg})
                            : shifted[DIVS_WIDTH-1:0];
            quo_reg <= {quo_reg[DIVD_WIDTH-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.quot = quo_reg;
    assign res.rem  = rem_reg;

endmodule

### sv/hyperbolic_diophantine_solver.sv
// the a-zero case goes straight to the summary, the p-zero case uses up to two
// divisions; otherwise one division per trial divisor i up to sqrt|p| plus up to two
// per candidate, all on the single 33-step serial divider
// throughput: one transaction at a time, s_tready is high only while idle
// reset: aresetn synchronous active low clears the sequencer and output valid
// depends on hds_pkg and hds_div
module hyperbolic_diophantine_solver import hds_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // coef_xy[15:0] coef_x[31:16] coef_y[47:32] rhs[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // sol_x[33:0] sol_y[67:34] status[69:68]
                                  // total_count[85:70] truncated[86] zero pad
    output logic        m_tuser,  // is_summary
    output logic        m_tlast   // last
);

    state_t state_reg, state_next;

    // coefficients of the transaction in flight
    logic signed [COEF_WIDTH-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [PROD_WIDTH-1:0] p_reg;        // a*d + b*c, first holds a*d
    logic        [DIVD_WIDTH-1:0] ap_reg;       // |p|
    logic        [COEF_WIDTH-1:0] i_reg;        // trial divisor
    logic        [DIVD_WIDTH:0]   sq_reg;       // i*i, kept by increments
    logic        [DIVD_WIDTH-1:0] q0_reg;       // |p| / i
    logic        [1:0]            k_reg;        // candidate index of this divisor
    logic signed [XY_WIDTH-1:0]   x_reg, y_reg;
    logic        [CNT_WIDTH-1:0]  count_reg;
    logic        [LIST_WIDTH-1:0] listed_reg;
    logic                         trunc_reg;
    status_t                      status_reg;

    // output register
    logic                         m_valid_reg;
    logic                         m_summ_reg;
    logic signed [XY_WIDTH-1:0]   m_x_reg, m_y_reg;
    status_t                      m_status_reg;
    logic        [CNT_WIDTH-1:0]  m_count_reg;
    logic                         m_trunc_reg;

    // shared divider
    logic                  div_start;
    logic [DIVD_WIDTH-1:0] div_dividend;
    logic [DIVS_WIDTH-1:0] div_divisor;
    div_res_t              div_res;

    // single shared multiplier
    logic signed [COEF_WIDTH-1:0]   mul_l, mul_r;
    logic signed [2*COEF_WIDTH-1:0] mul_prod;

    logic signed [XY_WIDTH-1:0] pq, i_s, cand_d, cand_q, num_x, num_y;
    logic        [DIVS_WIDTH-1:0] abs_a;
    logic                       out_free;
    logic                       list_room;
    logic                       last_cand;

    hds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    assign mul_l    = (state_reg == ST_MUL_AD) ? a_reg : b_reg;
    assign mul_r    = (state_reg == ST_MUL_AD) ? d_reg : c_reg;
    assign mul_prod = mul_l * mul_r;

    assign abs_a = a_reg[COEF_WIDTH-1] ? DIVS_WIDTH'(-a_reg) : DIVS_WIDTH'(a_reg);

    // signed p/i and the candidate divisor d with its cofactor p/d
    assign pq  = p_reg[PROD_WIDTH-1] ? -XY_WIDTH'(q0_reg) : XY_WIDTH'(q0_reg);
    assign i_s = XY_WIDTH'(i_reg);

    always_comb begin
        unique case (k_reg)
            2'd0: begin cand_d = i_s;  cand_q = pq;   end
            2'd1: begin cand_d = -i_s; cand_q = -pq;  end
            2'd2: begin cand_d = pq;   cand_q = i_s;  end
            default: begin cand_d = -pq; cand_q = -i_s; end
        endcase
    end

    assign num_x = cand_d - XY_WIDTH'(c_reg);
    assign num_y = cand_q - XY_WIDTH'(b_reg);

    assign out_free  = !m_valid_reg || m_tready;
    assign list_room = listed_reg < LIST_WIDTH'(MAX_LISTED);
    // square divisor: only +i and -i
    assign last_cand = (k_reg == 2'd3) || (k_reg == 2'd1 && q0_reg == DIVD_WIDTH'(i_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:        if (s_tvalid) state_next = ST_MUL_AD;
            ST_MUL_AD:      state_next = ST_MUL_BC;
            ST_MUL_BC:      state_next = ST_CHECK;
            ST_CHECK: begin
                if (a_reg == '0)      state_next = ST_SUMMARY;
                else if (p_reg == '0) state_next = ST_ZERO_C;
                else                  state_next = ST_LOOP;
            end
            ST_ZERO_C:      state_next = ST_ZERO_C_WAIT;
            ST_ZERO_C_WAIT: if (div_res.done) begin
                state_next = (div_res.rem == '0) ? ST_SUMMARY : ST_ZERO_B;
            end
            ST_ZERO_B:      state_next = ST_ZERO_B_WAIT;
            ST_ZERO_B_WAIT: if (div_res.done) state_next = ST_SUMMARY;
            ST_LOOP:        state_next = (sq_reg > {1'b0, ap_reg}) ? ST_SUMMARY : ST_DIV_I_WAIT;
            ST_DIV_I_WAIT:  if (div_res.done) begin
                state_next = (div_res.rem == '0) ? ST_CAND : ST_LOOP;
            end
            ST_CAND:        state_next = ST_DIV_X_WAIT;
            ST_DIV_X_WAIT:  if (div_res.done) begin
                state_next = (div_res.rem == '0) ? ST_DIV_Y_WAIT : ST_NEXT_CAND;
            end
            ST_DIV_Y_WAIT:  if (div_res.done) begin
                state_next = (div_res.rem == '0) ? ST_FOUND : ST_NEXT_CAND;
            end
            ST_FOUND:       if (!list_room || out_free) state_next = ST_NEXT_CAND;
            ST_NEXT_CAND:   state_next = last_cand ? ST_LOOP : ST_CAND;
            ST_SUMMARY:     if (out_free) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // divider control and handshake outputs
    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = abs_a;
        unique case (state_reg)
            ST_ZERO_C: begin
                div_start    = 1'b1;
                div_dividend = c_reg[COEF_WIDTH-1] ? DIVD_WIDTH'(-PROD_WIDTH'(c_reg))
                                                   : DIVD_WIDTH'(c_reg);
            end
            ST_ZERO_C_WAIT: begin
                div_dividend = '0;
            end
            ST_ZERO_B: begin
                div_start    = 1'b1;
                div_dividend = b_reg[COEF_WIDTH-1] ? DIVD_WIDTH'(-PROD_WIDTH'(b_reg))
                                                   : DIVD_WIDTH'(b_reg);
            end
            ST_LOOP: begin
                div_start    = sq_reg <= {1'b0, ap_reg};
                div_dividend = ap_reg;
                div_divisor  = i_reg;
            end
            ST_CAND: begin
                div_start    = 1'b1;
                div_dividend = num_x[XY_WIDTH-1] ? DIVD_WIDTH'(-num_x) : DIVD_WIDTH'(num_x);
            end
            ST_DIV_X_WAIT: begin
                // chain the y division right behind an exact x division
                div_start    = div_res.done && div_res.rem == '0;
                div_dividend = num_y[XY_WIDTH-1] ? DIVD_WIDTH'(-num_y) : DIVD_WIDTH'(num_y);
            end
            default: begin
                div_dividend = '0;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                a_reg      <= s_tdata[15:0];
                b_reg      <= s_tdata[31:16];
                c_reg      <= s_tdata[47:32];
                d_reg      <= s_tdata[63:48];
                count_reg  <= '0;
                listed_reg <= '0;
                trunc_reg  <= 1'b0;
                status_reg <= STATUS_FINITE;
                i_reg      <= COEF_WIDTH'(1);
                sq_reg     <= (DIVD_WIDTH+1)'(1);
            end
            ST_MUL_AD: p_reg <= PROD_WIDTH'(mul_prod);
            ST_MUL_BC: p_reg <= p_reg + PROD_WIDTH'(mul_prod);
            ST_CHECK: begin
                ap_reg <= p_reg[PROD_WIDTH-1] ? DIVD_WIDTH'(-p_reg) : DIVD_WIDTH'(p_reg);
                if (a_reg == '0) status_reg <= STATUS_A_ZERO;
            end
            ST_ZERO_C_WAIT: begin
                if (div_res.done && div_res.rem == '0) status_reg <= STATUS_INFINITE;
            end
            ST_ZERO_B_WAIT: begin
                if (div_res.done && div_res.rem == '0) status_reg <= STATUS_INFINITE;
            end
            ST_DIV_I_WAIT: begin
                if (div_res.done) begin
                    q0_reg <= div_res.quot;
                    k_reg  <= 2'd0;
                    if (div_res.rem != '0) begin
                        i_reg  <= i_reg + 1'b1;
                        sq_reg <= sq_reg + (DIVD_WIDTH+1)'({i_reg, 1'b1});
                    end
                end
            end
            ST_DIV_X_WAIT: begin
                x_reg <= (num_x[XY_WIDTH-1] ^ a_reg[COEF_WIDTH-1])
                       ? -XY_WIDTH'(div_res.quot) : XY_WIDTH'(div_res.quot);
            end
            ST_DIV_Y_WAIT: begin
                y_reg <= (num_y[XY_WIDTH-1] ^ a_reg[COEF_WIDTH-1])
                       ? -XY_WIDTH'(div_res.quot) : XY_WIDTH'(div_res.quot);
            end
            ST_FOUND: begin
                if (!list_room || out_free) begin
                    if (count_reg != '1) count_reg <= count_reg + 1'b1;
                    if (list_room) listed_reg <= listed_reg + 1'b1;
                    else           trunc_reg  <= 1'b1;
                end
            end
            ST_NEXT_CAND: begin
                k_reg <= k_reg + 1'b1;
                if (last_cand) begin
                    i_reg  <= i_reg + 1'b1;
                    sq_reg <= sq_reg + (DIVD_WIDTH+1)'({i_reg, 1'b1});
                end
            end
            default: begin
                k_reg <= k_reg;
            end
        endcase
    end

    // output register: loads a pair while the list has room, or the summary, when the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == ST_FOUND && list_room && out_free)
                     || (state_reg == ST_SUMMARY && out_free)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (state_reg == ST_SUMMARY) begin
                m_summ_reg   <= 1'b1;
                m_x_reg      <= '0;
                m_y_reg      <= '0;
                m_status_reg <= status_reg;
                m_count_reg  <= count_reg;
                m_trunc_reg  <= trunc_reg;
            end else if (state_reg == ST_FOUND) begin
                m_summ_reg   <= 1'b0;
                m_x_reg      <= x_reg;
                m_y_reg      <= y_reg;
                m_status_reg <= STATUS_FINITE;
                m_count_reg  <= '0;
                m_trunc_reg  <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_summ_reg;
    assign m_tlast  = m_summ_reg;
    assign m_tdata  = {1'b0, m_trunc_reg, m_count_reg, m_status_reg, m_y_reg, m_x_reg};

endmodule
